// ===== design/fcrs_pkg.sv =====
// Package for the fog color and range slew core.
// Holds field widths, item kind codes, the roll-out range constant and the result type.
// No dependencies.
package fcrs_pkg;

	localparam int COLOR_W = 16;
	localparam int RANGE_W = 24;
	localparam int RATE_W  = 24;
	localparam int NRATE_W = 23;
	localparam int DT_W    = 16;
	localparam int MODE_W  = 3;
	localparam int KIND_W  = 3;
	localparam int IN_W    = 192;
	localparam int OUT_W   = 104;

	// 4096.0 in signed Q15.8
	localparam logic signed [RANGE_W-1:0] ROLL_OUT_RANGE = 24'sh100000;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK     = 3'd0,
		KIND_FADE     = 3'd1,
		KIND_EXPLICIT = 3'd2,
		KIND_ROLL_OUT = 3'd3,
		KIND_DISABLE  = 3'd4
	} kind_t;

	// one result item: the current values after a request
	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic signed [RANGE_W-1:0] far_v;
		logic signed [RANGE_W-1:0] near_v;
		logic [COLOR_W-1:0]        blue;
		logic [COLOR_W-1:0]        green;
		logic [COLOR_W-1:0]        red;
	} res_t;

endpackage

// ===== design/fcrs_lane.sv =====
// One slew lane: step = (rate * dt) >> 16, then move the current value toward its goal.
// Depends on fcrs_pkg for the rate and dt widths.
module fcrs_lane import fcrs_pkg::*; #(
	parameter int VAL_W     = 16,
	parameter bit IS_SIGNED = 1'b0
) (
	input  logic [VAL_W-1:0]  now_v,
	input  logic [VAL_W-1:0]  goal,
	input  logic [RATE_W-1:0] rate,
	input  logic [DT_W-1:0]   dt,
	output logic [VAL_W-1:0]  next_v
);

	localparam int X_W  = VAL_W + 2;
	localparam int P_W  = RATE_W + DT_W;
	localparam int S_W  = P_W - 16;
	localparam int CM_W = (X_W > S_W) ? X_W : S_W;

	logic [P_W-1:0]        prod;
	logic [S_W-1:0]        step;
	logic signed [X_W-1:0] now_x;
	logic signed [X_W-1:0] goal_x;
	logic signed [X_W-1:0] diff;
	logic [X_W-1:0]        mag;
	logic [CM_W-1:0]       mag_c;
	logic [CM_W-1:0]       step_c;
	logic [X_W-1:0]        step_x;

	// step size for this tick
	assign prod = P_W'(rate) * P_W'(dt);
	assign step = prod[P_W-1:16];

	// distance to goal, widened so it cannot wrap
	assign now_x  = {{2{IS_SIGNED & now_v[VAL_W-1]}}, now_v};
	assign goal_x = {{2{IS_SIGNED & goal[VAL_W-1]}}, goal};
	assign diff   = goal_x - now_x;
	assign mag    = diff[X_W-1] ? X_W'(-diff) : X_W'(diff);

	assign mag_c  = CM_W'(mag);
	assign step_c = CM_W'(step);
	assign step_x = step_c[X_W-1:0];

	// snap when within one step, else move by one step (step < mag here, no overshoot)
	always_comb begin
		if (mag_c <= step_c) begin
			next_v = goal;
		end else if (diff[X_W-1]) begin
			next_v = now_v - step_x[VAL_W-1:0];
		end else begin
			next_v = now_v + step_x[VAL_W-1:0];
		end
	end

endmodule

// ===== design/fcrs_outq.sv =====
// Two-entry result queue between the state update and the result channel.
// Depends on fcrs_pkg for the result type.
module fcrs_outq import fcrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	input  logic pop,
	output logic full,
	output logic valid,
	output res_t head
);

	res_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q[1];
	assign valid = cnt_q != 2'd0;
	assign head  = ent_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_data;
	end

endmodule

// ===== design/fog_color_range_slew_core.sv =====
// Top level of the fog color and range slew core.
// Depends on fcrs_pkg, fcrs_lane and fcrs_outq.
//
// Usage:
//   Requests enter on the s_ group (tvalid/tready/tdata/tuser); tuser carries
//   the request kind (tick, fade, explicit set, roll out, disable).
//   Every request yields exactly one result on the m_ group: the current
//   color, near and far range and fog mode after that request.
//   Each result enters the result queue as its request is accepted.
//   Throughput: one request per cycle while the result queue is not full. Five
//   slew lanes (three color, two range) each with its own rate*dt multiplier
//   update the state in the accept cycle, so the next request sees it at once.
//   Results wait in a two-entry queue; s_tready drops only while that queue
//   is full, so a stalled receiver holds back new requests after two results.
//   Reset clears all current values, goals, rates and the mode (fog off) and
//   empties the result queue.
module fog_color_range_slew_core import fcrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// dt, red_in, green_in, blue_in, near_in, far_in, colour_rate_in,
	// near_rate_in, far_rate_in, mode_in (lowest first), zero padded
	input  logic [IN_W-1:0]   s_tdata,
	// kind
	input  logic [KIND_W-1:0] s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// red_out, green_out, blue_out, near_out, far_out, mode_out (lowest first), zero padded
	output logic [OUT_W-1:0]  m_tdata
);

	// state
	logic [COLOR_W-1:0] col_now_q  [3];
	logic [COLOR_W-1:0] col_goal_q [3];
	logic [RANGE_W-1:0] rng_now_q  [2];
	logic [RANGE_W-1:0] rng_goal_q [2];
	logic [RATE_W-1:0]  col_rate_q;
	logic [RATE_W-1:0]  rng_rate_q [2];
	logic [MODE_W-1:0]  mode_q;

	logic [COLOR_W-1:0] col_now_n  [3];
	logic [COLOR_W-1:0] col_goal_n [3];
	logic [RANGE_W-1:0] rng_now_n  [2];
	logic [RANGE_W-1:0] rng_goal_n [2];
	logic [RATE_W-1:0]  col_rate_n;
	logic [RATE_W-1:0]  rng_rate_n [2];
	logic [MODE_W-1:0]  mode_n;

	logic [COLOR_W-1:0] col_slew [3];
	logic [RANGE_W-1:0] rng_slew [2];

	// request fields
	logic [DT_W-1:0]    dt;
	logic [COLOR_W-1:0] col_in [3];
	logic [RANGE_W-1:0] near_in;
	logic [RANGE_W-1:0] far_in;
	logic [RATE_W-1:0]  crate_in;
	logic [NRATE_W-1:0] nrate_in;
	logic [NRATE_W-1:0] frate_in;
	logic [MODE_W-1:0]  mode_in;

	logic accept;
	logic q_full;
	res_t res;
	res_t head;

	assign dt        = s_tdata[15:0];
	assign col_in[0] = s_tdata[31:16];
	assign col_in[1] = s_tdata[47:32];
	assign col_in[2] = s_tdata[63:48];
	assign near_in   = s_tdata[87:64];
	assign far_in    = s_tdata[111:88];
	assign crate_in  = s_tdata[135:112];
	assign nrate_in  = s_tdata[158:136];
	assign frate_in  = s_tdata[181:159];
	assign mode_in   = s_tdata[184:182];

	assign s_tready = ~q_full;
	assign accept   = s_tvalid & s_tready;

	// color lanes
	for (genvar i = 0; i < 3; i++) begin : g_col
		fcrs_lane #(.VAL_W(COLOR_W), .IS_SIGNED(1'b0)) u_lane (
			.now_v  (col_now_q[i]),
			.goal   (col_goal_q[i]),
			.rate   (col_rate_q),
			.dt     (dt),
			.next_v (col_slew[i])
		);
	end

	// range lanes
	for (genvar i = 0; i < 2; i++) begin : g_rng
		fcrs_lane #(.VAL_W(RANGE_W), .IS_SIGNED(1'b1)) u_lane (
			.now_v  (rng_now_q[i]),
			.goal   (rng_goal_q[i]),
			.rate   (rng_rate_q[i]),
			.dt     (dt),
			.next_v (rng_slew[i])
		);
	end

	// next state by request kind
	always_comb begin
		col_now_n  = col_now_q;
		col_goal_n = col_goal_q;
		rng_now_n  = rng_now_q;
		rng_goal_n = rng_goal_q;
		col_rate_n = col_rate_q;
		rng_rate_n = rng_rate_q;
		mode_n     = mode_q;
		case (s_tuser)
			KIND_TICK: begin
				if (mode_q != '0) begin
					col_now_n = col_slew;
					rng_now_n = rng_slew;
				end
			end
			KIND_FADE: begin
				if (mode_q == '0) begin
					col_now_n    = col_in;
					rng_now_n[0] = far_in;
					rng_now_n[1] = far_in;
				end
				col_goal_n    = col_in;
				rng_goal_n[0] = near_in;
				rng_goal_n[1] = far_in;
				mode_n        = mode_in;
				col_rate_n    = crate_in;
				rng_rate_n[0] = RATE_W'(nrate_in);
				rng_rate_n[1] = RATE_W'(frate_in);
			end
			KIND_EXPLICIT: begin
				mode_n        = mode_in;
				col_now_n     = col_in;
				col_goal_n    = col_in;
				rng_now_n[0]  = near_in;
				rng_now_n[1]  = far_in;
				rng_goal_n[0] = near_in;
				rng_goal_n[1] = far_in;
			end
			KIND_ROLL_OUT: begin
				rng_rate_n[0] = RATE_W'(nrate_in);
				rng_rate_n[1] = {nrate_in, 1'b0};
				rng_goal_n[0] = ROLL_OUT_RANGE;
				rng_goal_n[1] = ROLL_OUT_RANGE;
				col_rate_n    = crate_in;
				col_goal_n    = col_in;
			end
			KIND_DISABLE: mode_n = '0;
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				col_now_q[i]  <= '0;
				col_goal_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				rng_now_q[i]  <= '0;
				rng_goal_q[i] <= '0;
				rng_rate_q[i] <= '0;
			end
			col_rate_q <= '0;
			mode_q     <= '0;
		end else if (accept) begin
			col_now_q  <= col_now_n;
			col_goal_q <= col_goal_n;
			rng_now_q  <= rng_now_n;
			rng_goal_q <= rng_goal_n;
			col_rate_q <= col_rate_n;
			rng_rate_q <= rng_rate_n;
			mode_q     <= mode_n;
		end
	end

	// merge lane results into one result item
	assign res.red    = col_now_n[0];
	assign res.green  = col_now_n[1];
	assign res.blue   = col_now_n[2];
	assign res.near_v = rng_now_n[0];
	assign res.far_v  = rng_now_n[1];
	assign res.mode   = mode_n;

	fcrs_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.pop       (m_tvalid & m_tready),
		.full      (q_full),
		.valid     (m_tvalid),
		.head      (head)
	);

	assign m_tdata = {5'd0, head};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for fog_color_range_slew_core.
// Sends requests on the s_ stream, predicts each result and checks every m_ result in order.
// Depends on fcrs_pkg and the core RTL.
module tb_top;
	import fcrs_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 200;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_PRINTS     = 40;

	// kind codes the core must ignore
	localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [DT_W-1:0]           dt;
		logic [COLOR_W-1:0]        red;
		logic [COLOR_W-1:0]        green;
		logic [COLOR_W-1:0]        blue;
		logic signed [RANGE_W-1:0] near_v;
		logic signed [RANGE_W-1:0] far_v;
		logic [RATE_W-1:0]         color_rate;
		logic [NRATE_W-1:0]        near_rate;
		logic [NRATE_W-1:0]        far_rate;
		logic [MODE_W-1:0]         mode;
	} fog_req_t;

	// one request as offered, with a hand-written result where one is given
	typedef struct {
		fog_req_t req;
		bit       typed;
		res_t     exp;
	} fog_row_t;

	localparam res_t NO_EXP = '0;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic [KIND_W-1:0] s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;

	fog_row_t offered_q [$];
	res_t     fog_expect_q [$];
	fog_row_t dir_rows [$];
	int       mismatch_cnt = 0;
	int       quiet_cycles = 0;
	bit       tx_idle;
	bit       rx_idle;
	bit       hold_req;

	// predicted core state
	logic [COLOR_W-1:0]        col_now [3];
	logic [COLOR_W-1:0]        col_goal [3];
	logic signed [RANGE_W-1:0] rng_now [2];
	logic signed [RANGE_W-1:0] rng_goal [2];
	logic [RATE_W-1:0]         col_rate;
	logic [RATE_W-1:0]         rng_rate [2];
	logic [MODE_W-1:0]         fog_mode;

	fog_color_range_slew_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic void fog_state_clear();
		for (int i = 0; i < 3; i++) begin
			col_now[i]  = '0;
			col_goal[i] = '0;
		end
		for (int i = 0; i < 2; i++) begin
			rng_now[i]  = '0;
			rng_goal[i] = '0;
			rng_rate[i] = '0;
		end
		col_rate = '0;
		fog_mode = '0;
	endfunction

	// move one channel toward its goal, snapping when within one step
	function automatic longint slew_toward(longint cur, longint goal, longint step);
		longint d;
		longint mag;
		d = goal - cur;
		mag = (d < 0) ? -d : d;
		if (mag <= step)
			return goal;
		return (d < 0) ? cur - step : cur + step;
	endfunction

	// apply one request to the predicted state, return the values reported
	function automatic res_t fog_advance(fog_req_t r);
		logic [COLOR_W-1:0] col_in [3];
		longint cstep;
		longint rstep;
		res_t o;
		col_in[0] = r.red;
		col_in[1] = r.green;
		col_in[2] = r.blue;
		case (r.kind)
			KIND_TICK: begin
				if (fog_mode != '0) begin
					cstep = (longint'(col_rate) * longint'(r.dt)) >>> 16;
					for (int i = 0; i < 3; i++)
						col_now[i] = COLOR_W'(slew_toward(longint'(col_now[i]),
							longint'(col_goal[i]), cstep));
					for (int i = 0; i < 2; i++) begin
						rstep = (longint'(rng_rate[i]) * longint'(r.dt)) >>> 16;
						rng_now[i] = RANGE_W'(slew_toward(longint'(rng_now[i]),
							longint'(rng_goal[i]), rstep));
					end
				end
			end
			KIND_FADE: begin
				// fog off: jump straight to the new color, both ranges to far
				if (fog_mode == '0) begin
					for (int i = 0; i < 3; i++)
						col_now[i] = col_in[i];
					rng_now[0] = r.far_v;
					rng_now[1] = r.far_v;
				end
				for (int i = 0; i < 3; i++)
					col_goal[i] = col_in[i];
				rng_goal[0] = r.near_v;
				rng_goal[1] = r.far_v;
				fog_mode = r.mode;
				col_rate = r.color_rate;
				rng_rate[0] = {1'b0, r.near_rate};
				rng_rate[1] = {1'b0, r.far_rate};
			end
			KIND_EXPLICIT: begin
				fog_mode = r.mode;
				for (int i = 0; i < 3; i++) begin
					col_now[i]  = col_in[i];
					col_goal[i] = col_in[i];
				end
				rng_now[0]  = r.near_v;
				rng_now[1]  = r.far_v;
				rng_goal[0] = r.near_v;
				rng_goal[1] = r.far_v;
			end
			KIND_ROLL_OUT: begin
				rng_rate[0] = {1'b0, r.near_rate};
				rng_rate[1] = {r.near_rate, 1'b0};
				rng_goal[0] = ROLL_OUT_RANGE;
				rng_goal[1] = ROLL_OUT_RANGE;
				col_rate = r.color_rate;
				for (int i = 0; i < 3; i++)
					col_goal[i] = col_in[i];
			end
			KIND_DISABLE: fog_mode = '0;
			default: ;
		endcase
		o.red    = col_now[0];
		o.green  = col_now[1];
		o.blue   = col_now[2];
		o.near_v = rng_now[0];
		o.far_v  = rng_now[1];
		o.mode   = fog_mode;
		return o;
	endfunction

	function automatic logic [IN_W-1:0] pack_req(fog_req_t r);
		return IN_W'({r.mode, r.far_rate, r.near_rate, r.color_rate, r.far_v, r.near_v,
			r.blue, r.green, r.red, r.dt});
	endfunction

	function automatic fog_req_t mk_req(logic [KIND_W-1:0] kind, logic [DT_W-1:0] dt,
			logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green, logic [COLOR_W-1:0] blue,
			logic [RANGE_W-1:0] near_v, logic [RANGE_W-1:0] far_v,
			logic [RATE_W-1:0] crate, logic [NRATE_W-1:0] nrate,
			logic [NRATE_W-1:0] frate, logic [MODE_W-1:0] mode);
		fog_req_t r;
		r.kind = kind;
		r.dt = dt;
		r.red = red;
		r.green = green;
		r.blue = blue;
		r.near_v = near_v;
		r.far_v = far_v;
		r.color_rate = crate;
		r.near_rate = nrate;
		r.far_rate = frate;
		r.mode = mode;
		return r;
	endfunction

	function automatic res_t mk_res(logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
			logic [COLOR_W-1:0] blue, logic [RANGE_W-1:0] near_v,
			logic [RANGE_W-1:0] far_v, logic [MODE_W-1:0] mode);
		res_t o;
		o.red = red;
		o.green = green;
		o.blue = blue;
		o.near_v = near_v;
		o.far_v = far_v;
		o.mode = mode;
		return o;
	endfunction

	// append one row to the directed table
	function automatic void add_row(fog_req_t req, bit typed, res_t exp);
		fog_row_t row;
		row.req = req;
		row.typed = typed;
		row.exp = exp;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	function automatic logic [RANGE_W-1:0] rand_range();
		case ($urandom_range(0, 9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return ROLL_OUT_RANGE + RANGE_W'($urandom_range(0, 511)) - 24'd256;
			default: return RANGE_W'($urandom());
		endcase
	endfunction

	// mostly small or full-width rates, with zero and all-ones mixed in
	function automatic logic [RATE_W-1:0] rand_rate();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return RATE_W'($urandom_range(1, 4095));
			default: return RATE_W'($urandom());
		endcase
	endfunction

	function automatic fog_req_t rand_req();
		fog_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 52)
			r.kind = KIND_TICK;
		else if (pick < 64)
			r.kind = KIND_FADE;
		else if (pick < 72)
			r.kind = KIND_EXPLICIT;
		else if (pick < 82)
			r.kind = KIND_ROLL_OUT;
		else if (pick < 90)
			r.kind = KIND_DISABLE;
		else if (pick < 94)
			r.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
		else
			r.kind = KIND_TICK;
		case ($urandom_range(0, 9))
			0: r.dt = '0;
			1: r.dt = '1;
			2, 3: r.dt = DT_W'($urandom_range(1, 255));
			default: r.dt = DT_W'($urandom());
		endcase
		r.red   = COLOR_W'($urandom());
		r.green = COLOR_W'($urandom());
		r.blue  = COLOR_W'($urandom());
		if ($urandom_range(0, 7) == 0)
			r.blue = ($urandom_range(0, 1) == 0) ? '0 : '1;
		r.near_v = rand_range();
		r.far_v = rand_range();
		r.color_rate = rand_rate();
		r.near_rate = NRATE_W'(rand_rate());
		r.far_rate = NRATE_W'(rand_rate());
		// fog mostly on so ticks do work
		r.mode = ($urandom_range(0, 3) == 0) ? MODE_W'($urandom_range(0, 7))
			: MODE_W'($urandom_range(1, 7));
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_PRINTS)
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] exp);
		if (got !== exp)
			report_mismatch(what, got, exp);
	endtask

	// offer one request and hold it until the core takes it
	task automatic send_req(fog_row_t row);
		offered_q.insert(offered_q.size(), row);
		s_tdata <= pack_req(row.req);
		s_tuser <= row.req.kind;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		fog_row_t row;
		res_t got;
		res_t exp;
		res_t pred;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (fog_expect_q.size() == 0)
					report_mismatch("result with none pending", m_tdata[31:0], '0);
				else begin
					exp = fog_expect_q.pop_front();
					got = res_t'(m_tdata[$bits(res_t)-1:0]);
					check_field("red", got.red, exp.red);
					check_field("green", got.green, exp.green);
					check_field("blue", got.blue, exp.blue);
					check_field("near", got.near_v, exp.near_v);
					check_field("far", got.far_v, exp.far_v);
					check_field("mode", got.mode, exp.mode);
				end
			end
			if (s_tvalid && s_tready) begin
				row = offered_q.pop_front();
				pred = fog_advance(row.req);
				fog_expect_q.insert(fog_expect_q.size(), row.typed ? row.exp : pred);
			end
		end
	end

	// end the run if neither side moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else if (rx_idle && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13) - 1) @(posedge clk);
			end else
				m_tready <= 1'b1;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_req = 1'b0;
		fog_state_clear();

		// directed table
		add_row(mk_req(KIND_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, 0, 0, 0, 0));
		add_row(mk_req(KIND_EXPLICIT, 0, 16'hFFFF, 0, 16'hFFFF, 24'h7FFFFF,
			24'h800000, 0, 0, 0, 3'd7), 1'b1,
			mk_res(16'hFFFF, 0, 16'hFFFF, 24'h7FFFFF, 24'h800000, 3'd7));
		add_row(mk_req(KIND_EXPLICIT, 0, 0, 16'hFFFF, 0, 24'h800000, 24'h7FFFFF,
			0, 0, 0, 3'd1), 1'b1, mk_res(0, 16'hFFFF, 0, 24'h800000, 24'h7FFFFF, 3'd1));
		add_row(mk_req(KIND_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(0, 16'hFFFF, 0, 24'h800000, 24'h7FFFFF, 3'd1));
		add_row(mk_req(KIND_DISABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3'd7), 1'b1,
			mk_res(0, 16'hFFFF, 0, 24'h800000, 24'h7FFFFF, 3'd0));
		// fade from fog off snaps current values
		add_row(mk_req(KIND_FADE, 0, 16'h1000, 16'h8000, 16'hF000, 24'h000100,
			24'h010000, 24'h100000, 23'h040000, 23'h7FFFFF, 3'd2), 1'b1,
			mk_res(16'h1000, 16'h8000, 16'hF000, 24'h010000, 24'h010000, 3'd2));
		add_row(mk_req(KIND_TICK, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_EXP);
		add_row(mk_req(KIND_TICK, 16'h0100, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_EXP);
		add_row(mk_req(KIND_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_EXP);
		// fade while fog on keeps current values
		add_row(mk_req(KIND_FADE, 0, 16'hFFFF, 0, 16'h8000, 24'h7FFFFF,
			24'h800000, 24'hFFFFFF, 23'h7FFFFF, 23'h001234, 3'd5), 1'b0, NO_EXP);
		add_row(mk_req(KIND_TICK, 16'h8000, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_EXP);
		add_row(mk_req(KIND_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_EXP);
		add_row(mk_req(KIND_ROLL_OUT, 16'hFFFF, 0, 16'hFFFF, 16'h0001, 24'h123456,
			24'h654321, 24'h000800, 23'h7FFFFF, 23'h000001, 3'd3), 1'b0, NO_EXP);
		add_row(mk_req(KIND_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_EXP);
		add_row(mk_req(KIND_TICK, 16'h0001, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_EXP);
		// unused kinds change nothing
		add_row(mk_req(KIND_SPARE_LO, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b0,
			NO_EXP);
		add_row(mk_req(KIND_SPARE_MID, '1, 0, 0, 0, 0, 0, '1, '1, '1, 0), 1'b0,
			NO_EXP);
		add_row(mk_req(KIND_SPARE_HI, 0, '1, 0, '1, 24'h800000, 24'h7FFFFF, 0, 0, 0,
			3'd4), 1'b0, NO_EXP);
		// fade with mode zero turns fog off without a snap
		add_row(mk_req(KIND_FADE, 0, 16'h4444, 16'h5555, 16'h6666, 24'h000000,
			24'hFFFFFF, 24'h00FFFF, 23'h000FFF, 23'h0FFFFF, 3'd0), 1'b0, NO_EXP);
		add_row(mk_req(KIND_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_EXP);
		// zero rates: ticks leave every channel where it is
		add_row(mk_req(KIND_FADE, 0, 16'h0123, 16'hFEDC, 16'h7FFF, 24'h000200,
			24'hFFFE00, 0, 0, 0, 3'd6), 1'b0, NO_EXP);
		add_row(mk_req(KIND_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_EXP);
		add_row(mk_req(KIND_ROLL_OUT, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0,
			23'h000001, 0, 0), 1'b0, NO_EXP);
		add_row(mk_req(KIND_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_EXP);
		add_row(mk_req(KIND_DISABLE, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b0,
			NO_EXP);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_req(dir_rows[i]);

		// random traffic, both sides idling
		repeat (400)
			send_req('{rand_req(), 1'b0, NO_EXP});

		// receiver holds off while the sender keeps offering
		tx_idle = 1'b0;
		hold_req = 1'b1;
		repeat (300)
			send_req('{rand_req(), 1'b0, NO_EXP});

		// closing stretch at full rate
		rx_idle = 1'b0;
		repeat (300)
			send_req('{rand_req(), 1'b0, NO_EXP});
		s_tvalid <= 1'b0;

		while (offered_q.size() != 0 || fog_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
